>>> design/integer_determinant_engine_defines.svh
// Assertion macros used by the determinant engine port checker
`ifndef INTEGER_DETERMINANT_ENGINE_DEFINES_SVH
`define INTEGER_DETERMINANT_ENGINE_DEFINES_SVH

// Property under reset masking, antecedent overlapping the consequent
`define IDE_ASSERT_HOLDS(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("determinant engine check failed");

// Property checked in every cycle, consequent in the following cycle
`define IDE_ASSERT_NEXT(lbl, clk_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("determinant engine check failed");

`endif

>>> design/ide_pkg.sv
// Shared constants of the determinant engine
package ide_pkg;

  localparam int unsigned MaxOrderDefault = 4;
  localparam int unsigned DataWidth       = 32;
  localparam int unsigned SizeWidth       = 3;

endpackage

>>> design/ide_ram.sv
// Generic single write port RAM with registered read
module ide_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/integer_determinant_engine.sv
// Determinant engine: loads a square matrix and sums signed permutation products
// Usage:
//   Input channel in_*: one 32-bit two's complement matrix entry per beat, row-major.
//   Entries load one per cycle while in_tready is high.
//   Configuration cfg_*: cfg_wr_en writes the matrix order (0 acts as 1, values above
//   MAX_ORDER act as MAX_ORDER) and restarts the load; write only while idle.
//   After the n*n-th entry in_tready drops and the block works through every column
//   tuple of the odometer, all n^n of them: a non-permutation is skipped, and for a
//   permutation each row's entry is read from the entry memory and multiplied in
//   through one 32x32 multiplier, then one adder adds or subtracts the product.
//   The result beat on out_* holds the determinant modulo 2^32.
//   While a result waits in the output register, loading of the next matrix goes on;
//   the next result waits until the held one is taken.
//   Reset clears the load count, sets the order to 4 and empties the output register.
module integer_determinant_engine #(
  parameter int unsigned MAX_ORDER = ide_pkg::MaxOrderDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ide_pkg::DataWidth-1:0] in_tdata,    // [31:0] entry_value
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ide_pkg::DataWidth-1:0] out_tdata,   // [31:0] determinant
  input  logic                          cfg_wr_en,
  input  logic [ide_pkg::SizeWidth-1:0] cfg_wr_data
);

  localparam int unsigned Depth = MAX_ORDER * MAX_ORDER;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = $clog2(Depth + 1);
  localparam int unsigned DW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int unsigned SW    = ide_pkg::SizeWidth;
  localparam int unsigned W     = ide_pkg::DataWidth;

  typedef enum logic [2:0] {S_LOAD, S_CHECK, S_ISSUE, S_MUL, S_ACC, S_FIN} state_t;

  state_t          state_r;
  logic [SW-1:0]   size_r;
  logic [CW-1:0]   cnt_r;
  logic [DW-1:0]   dig_r [MAX_ORDER];
  logic [DW-1:0]   dig_nxt [MAX_ORDER];
  logic            wrap_nxt;
  logic [DW-1:0]   row_r;
  logic [W-1:0]    prod_r;
  logic [W-1:0]    acc_r;
  logic            neg_r;
  logic [W-1:0]    out_data_r;
  logic            out_valid_r;

  logic [SW-1:0]   order;
  logic [DW-1:0]   last_dig;
  logic [CW-1:0]   total;
  logic            is_perm;
  logic            parity;
  logic [AW-1:0]   raddr;
  logic [W-1:0]    rdata;
  logic            load_beat;
  logic [W-1:0]    mul_full;

  always_comb begin
    if (size_r == '0) begin
      order = SW'(1);
    end else if (size_r > SW'(MAX_ORDER)) begin
      order = SW'(MAX_ORDER);
    end else begin
      order = size_r;
    end
  end

  assign last_dig  = DW'(order - SW'(1));
  assign total     = CW'(order) * CW'(order);
  assign in_tready = (state_r == S_LOAD);
  assign load_beat = in_tvalid && in_tready;

  // odometer advance over the active digits
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int i = 0; i < MAX_ORDER; i++) begin
      dig_nxt[i] = dig_r[i];
      if (i < int'(order) && carry) begin
        if (dig_r[i] == last_dig) begin
          dig_nxt[i] = '0;
        end else begin
          dig_nxt[i] = dig_r[i] + DW'(1);
          carry      = 1'b0;
        end
      end
    end
    wrap_nxt = carry;
  end

  // distinct digits and inversion parity
  always_comb begin
    is_perm = 1'b1;
    parity  = 1'b0;
    for (int i = 0; i < MAX_ORDER; i++) begin
      for (int j = i + 1; j < MAX_ORDER; j++) begin
        if (j < int'(order)) begin
          if (dig_r[i] == dig_r[j]) begin
            is_perm = 1'b0;
          end
          if (dig_r[i] > dig_r[j]) begin
            parity = ~parity;
          end
        end
      end
    end
  end

  assign raddr    = AW'(AW'(row_r) * AW'(order)) + AW'(dig_r[row_r]);
  // only the low word of the product is kept
  assign mul_full = prod_r * rdata;

  ide_ram #(.Width(W), .Depth(Depth)) u_store (
    .clk   (clk),
    .we    (load_beat),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_tdata),
    .re    (state_r == S_ISSUE),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      size_r      <= SW'(4);
      cnt_r       <= '0;
      row_r       <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        dig_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_tready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
        cnt_r  <= '0;
      end
      case (state_r)
        S_LOAD: begin
          if (load_beat && !cfg_wr_en) begin
            if (cnt_r + CW'(1) >= total) begin
              cnt_r   <= '0;
              acc_r   <= '0;
              state_r <= S_CHECK;
              for (int i = 0; i < MAX_ORDER; i++) begin
                dig_r[i] <= '0;
              end
            end else begin
              cnt_r <= cnt_r + CW'(1);
            end
          end
        end
        S_CHECK: begin
          if (is_perm) begin
            prod_r  <= W'(1);
            row_r   <= '0;
            neg_r   <= parity;
            state_r <= S_ISSUE;
          end else begin
            dig_r   <= dig_nxt;
            state_r <= wrap_nxt ? S_FIN : S_CHECK;
          end
        end
        S_ISSUE: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r <= mul_full;
          if (row_r == last_dig) begin
            state_r <= S_ACC;
          end else begin
            row_r   <= row_r + DW'(1);
            state_r <= S_ISSUE;
          end
        end
        S_ACC: begin
          acc_r   <= neg_r ? (acc_r - prod_r) : (acc_r + prod_r);
          dig_r   <= dig_nxt;
          state_r <= wrap_nxt ? S_FIN : S_CHECK;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid_r || out_tready) begin
            out_data_r  <= acc_r;
            out_valid_r <= 1'b1;
            state_r     <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> design/ide_checker.sv
// Port-level checker for the determinant engine, bound to the top level
`include "integer_determinant_engine_defines.svh"

module ide_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [ide_pkg::DataWidth-1:0] out_tdata
);

  `IDE_ASSERT_HOLDS(a_stall_holds, clk, rst_n, out_tvalid && !out_tready, ##1 (out_tvalid && $stable(out_tdata)))
  `IDE_ASSERT_NEXT(a_reset_empty, clk, !rst_n, !out_tvalid)
  `IDE_ASSERT_HOLDS(a_result_after_busy, clk, rst_n, $rose(out_tvalid), $past(!in_tready))

endmodule

bind integer_determinant_engine ide_checker u_ide_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/sv/det_checker.sv
// Checker: watches the entry and result channels, predicts determinants and compares
`timescale 1ns / 100ps
module det_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  output int          fail_count,
  output int          pending,
  output int          dets_seen
);

  logic [31:0] entries [16];
  int unsigned loaded;
  logic [2:0]  order_reg;
  logic [31:0] dets_due [$];

  function automatic int unsigned order_of(logic [2:0] r);
    if (r == 0) return 1;
    if (r > 4) return 4;
    return r;
  endfunction

  function automatic logic [31:0] minor_det(int unsigned n, int unsigned row,
                                            int unsigned used);
    logic [31:0] acc;
    logic [31:0] term;
    bit neg;
    acc = 0;
    neg = 0;
    if (row + 1 >= n) begin
      for (int c = 0; c < n; c++)
        if (!used[c]) return entries[row * n + c];
      return 0;
    end
    for (int c = 0; c < n; c++) begin
      if (used[c]) continue;
      term = entries[row * n + c] * minor_det(n, row + 1, used | (1 << c));
      acc = neg ? acc - term : acc + term;
      neg = !neg;
    end
    return acc;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %08h expected %08h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  assign pending = dets_due.size();

  initial begin
    fail_count = 0;
    dets_seen = 0;
  end

  always @(posedge clk) begin
    int unsigned n;
    if (!rst_n) begin
      loaded = 0;
      order_reg = 3'd4;
      dets_due.delete();
    end else begin
      if (cfg_wr_en) begin
        order_reg = cfg_wr_data;
        loaded = 0;
      end
      if (in_tvalid && in_tready) begin
        n = order_of(order_reg);
        if (loaded >= n * n) loaded = 0;
        entries[loaded] = in_tdata;
        loaded++;
        if (loaded >= n * n) begin
          loaded = 0;
          dets_due.push_back(minor_det(n, 0, 0));
        end
      end
      if (out_tvalid && out_tready) begin
        dets_seen++;
        if (dets_due.size() == 0) report("unexpected determinant", out_tdata, 0);
        else begin
          if (out_tdata !== dets_due[0]) report("determinant", out_tdata, dets_due[0]);
          void'(dets_due.pop_front());
        end
      end
    end
  end
endmodule

>>> tb/sv/tb.sv
// Testbench top: drives matrices through the determinant engine and gives the verdict
`timescale 1ns / 100ps
module tb;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;
  logic        cfg_wr_en = 0;
  logic [2:0]  cfg_wr_data = 0;
  int          fail_count, pending, dets_seen;
  int          cycles = 0;
  int          entries_sent = 0;
  bit          stall_mode = 0;

  always #2 clk = ~clk;

  integer_determinant_engine DUT (.*);
  det_checker chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 1500000) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stalls: mostly short, occasionally long, sometimes none
  always @(negedge clk) begin
    if (stall_mode && $urandom_range(0, 3) == 0)
      out_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
    else if (!stall_mode)
      out_tready <= 1'b1;
  end

  function automatic logic [31:0] pick_entry();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 0;
      4: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  // valid stays high between back-to-back beats; drop it only for a gap
  task automatic send_entry(logic [31:0] v);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    while (!in_tready) @(negedge clk);
    @(negedge clk);
    entries_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic set_order(logic [2:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [2:0] order;
    int n;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: reset order 4 with extremes and identity-like matrices
    for (int i = 0; i < 16; i++) send_entry(i[0] ? 32'h8000_0000 : 32'h7fff_ffff);
    set_order(3'd0);
    send_entry(32'h8000_0000);
    send_entry(32'hffff_ffff);
    set_order(3'd7);
    for (int i = 0; i < 16; i++) send_entry((i % 5 == 0) ? 32'd1 : 32'd0);
    // size write during a load restarts loading
    set_order(3'd2);
    send_entry(32'd5);
    set_order(3'd2);
    for (int i = 0; i < 4; i++) send_entry(i + 2);
    stall_mode = 1;
    while (entries_sent < 700) begin
      order = 3'($urandom_range(0, 7));
      set_order(order);
      n = (order == 0) ? 1 : (order > 4 ? 4 : order);
      for (int m = 0; m < $urandom_range(1, 6); m++) begin
        for (int k = 0; k < n * n; k++) send_entry(pick_entry());
        if ($urandom_range(0, 9) == 0) drain();
      end
    end
    stall_mode = 0;
    drain();
    $display("covered %0d entries and %0d determinants over orders 1 to 4",
             entries_sent, dets_seen);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
